// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and the B3/S23 rule for the Life generation stream.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_W           = 11;
    localparam int MAX_SIDE_DEFAULT = 1024;
    localparam int GRID_RESET       = 1024;
    localparam int BIRTH_COUNT      = 3;
    localparam int STAY_COUNT       = 2;

    typedef enum logic {
        FUNC_CELL = 1'b0,
        FUNC_PAD  = 1'b1
    } func_t;

    typedef struct packed {
        func_t func;
        logic  cell_alive;
    } in_word_t;

    typedef struct packed {
        logic next_alive;
        logic last_of_generation;
    } out_word_t;

    // Next state of the center cell (bit 4) of a 3x3 window
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] cnt;
        logic       res;
        cnt = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                cnt = cnt + {3'b000, win[i]};
            end
        end
        if (win[4])
        begin
            res = (cnt == 4'(STAY_COUNT)) || (cnt == 4'(BIRTH_COUNT));
        end
        else
        begin
            res = (cnt == 4'(BIRTH_COUNT));
        end
        return res;
    endfunction

endpackage

// ===== rtl/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read that returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = lgs_pkg::MAX_SIDE_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lgs_column_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_column_cell
// One column (upper, middle, lower bit) of the 3x3 window. Cells form a chain
// and each takes its neighbor's column on every window shift.
// ----------------------------------------------------------------------------
module lgs_column_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       flush,
    input  logic       shift,
    input  logic       clear,
    input  logic [2:0] col_in,
    output logic [2:0] col
);

    logic [2:0] col_reg;
    logic [2:0] col_next;

    // Load zero at the start of a row, else take the neighbor column
    assign col_next = clear ? 3'b000 : col_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 3'b000;
        end
        else if (flush)
        begin
            col_reg <= 3'b000;
        end
        else if (shift)
        begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;

endmodule

// ===== rtl/lgs_result_fifo.sv =====
// ----------------------------------------------------------------------------
// lgs_result_fifo
// Four-entry result queue that takes up to two words per cycle and hands
// out one. Reports room when at least two entries are free.
// ----------------------------------------------------------------------------
module lgs_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  lgs_pkg::out_word_t word_a,
    input  logic              push_b,
    input  lgs_pkg::out_word_t word_b,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output lgs_pkg::out_word_t out_word
);

    lgs_pkg::out_word_t mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] wp_next;
    logic [1:0] rp_reg;
    logic [1:0] rp_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] push_cnt;
    logic [1:0] wp_b;
    logic       pop;

    assign pop      = out_valid && out_ready;
    assign push_cnt = {1'b0, push_a} + {1'b0, push_b};
    assign wp_b     = push_a ? (wp_reg + 2'd1) : wp_reg;

    // Advance pointers and fill level
    always_comb
    begin
        wp_next    = wp_reg + push_cnt;
        rp_next    = rp_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 2'd0;
            rp_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Store incoming words in order
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wp_reg] <= word_a;
        end
        if (push_b)
        begin
            mem_reg[wp_b] <= word_b;
        end
    end

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_word  = mem_reg[rp_reg];

endmodule

// ===== rtl/life_generation_stream.sv =====
// ----------------------------------------------------------------------------
// life_generation_stream
// One Life generation (B3/S23, dead border) over a raster cell stream.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the result queue has room; a column N-1 word yields up to two results.
// Path: results of a word pass the line-buffer read stage and the window stage,
// then the result queue; a full queue stalls both stages and the input.
// The registered read port of the line-buffer RAMs sets the stage count.
// Reset clears counters, window, pipeline and queue; line buffers keep data
// and are masked by row, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module life_generation_stream #(
    parameter int MAX_SIDE = lgs_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lgs_pkg::GRID_W-1:0] cfg_data,
    input  logic                      cell_valid,
    output logic                      cell_ready,
    input  lgs_pkg::in_word_t         cell_word,
    output logic                      result_valid,
    input  logic                      result_ready,
    output lgs_pkg::out_word_t        result_word
);

    localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam logic [SIDE_W-1:0] SIDE_RESET =
        SIDE_W'((lgs_pkg::GRID_RESET > MAX_SIDE) ? MAX_SIDE : lgs_pkg::GRID_RESET);

    typedef struct packed {
        logic bit_v;
        logic parity;
        logic row_ge1;
        logic row_ge2;
        logic col_first;
        logic col_last;
        logic row_last;
    } stage_t;

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_cfg;
    logic [COL_W-1:0]  col_reg;
    logic [SIDE_W-1:0] row_reg;
    logic              accept;
    logic              last_col;
    logic              last_row;
    logic              cell_bit;
    stage_t            stage_next;
    stage_t            b_reg;
    stage_t            c_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic              b_advance;
    logic              c_advance;
    logic              fifo_room;
    logic              rd0;
    logic              rd1;
    logic              up_bit;
    logic              mid_bit;
    logic [2:0]        new_col;
    logic [2:0]        col0;
    logic [2:0]        col1;
    logic [2:0]        col2;
    logic              push_a;
    logic              push_b;
    lgs_pkg::out_word_t word_a;
    lgs_pkg::out_word_t word_b;

    // Clamp the written size into 1..MAX_SIDE
    always_comb
    begin
        if (cfg_data == '0)
        begin
            side_cfg = SIDE_W'(1);
        end
        else if (32'(cfg_data) > MAX_SIDE)
        begin
            side_cfg = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_cfg = SIDE_W'(cfg_data);
        end
    end

    assign accept   = cell_valid && cell_ready;
    assign last_col = (SIDE_W'(col_reg) == (side_reg - SIDE_W'(1)));
    assign last_row = (row_reg == side_reg);
    assign cell_bit = !last_row && (cell_word.func == lgs_pkg::FUNC_CELL) &&
                      cell_word.cell_alive;

    // Raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (cfg_we)
        begin
            side_reg <= side_cfg;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : (row_reg + SIDE_W'(1));
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Line buffers by row parity: this row's bank also holds the row two above
    lgs_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_line0 (
        .clk   (clk),
        .we    (accept && !row_reg[0]),
        .waddr (col_reg),
        .wdata (cell_bit),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd0)
    );

    lgs_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_line1 (
        .clk   (clk),
        .we    (accept && row_reg[0]),
        .waddr (col_reg),
        .wdata (cell_bit),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd1)
    );

    // Position flags for the read stage
    always_comb
    begin
        stage_next.bit_v     = cell_bit;
        stage_next.parity    = row_reg[0];
        stage_next.row_ge1   = (row_reg != '0);
        stage_next.row_ge2   = (row_reg != '0) && (row_reg != SIDE_W'(1));
        stage_next.col_first = (col_reg == '0);
        stage_next.col_last  = last_col;
        stage_next.row_last  = last_row;
    end

    // Pipeline handshake
    assign c_advance  = c_valid_reg && fifo_room;
    assign b_advance  = b_valid_reg && (!c_valid_reg || c_advance);
    assign cell_ready = !b_valid_reg || !c_valid_reg || c_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept || (b_valid_reg && !b_advance);
            c_valid_reg <= b_advance || (c_valid_reg && !c_advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg <= stage_next;
        end
        if (b_advance)
        begin
            c_reg <= b_reg;
        end
    end

    // Mask unwritten rows and build the new window column
    assign up_bit  = b_reg.row_ge2 && (b_reg.parity ? rd1 : rd0);
    assign mid_bit = b_reg.row_ge1 && (b_reg.parity ? rd0 : rd1);
    assign new_col = {b_reg.bit_v, mid_bit, up_bit};

    // Window: newest column enters cell 2 and moves toward cell 0
    lgs_column_cell u_cell2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .flush  (cfg_we),
        .shift  (b_advance),
        .clear  (1'b0),
        .col_in (new_col),
        .col    (col2)
    );

    lgs_column_cell u_cell1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .flush  (cfg_we),
        .shift  (b_advance),
        .clear  (b_reg.col_first),
        .col_in (col2),
        .col    (col1)
    );

    lgs_column_cell u_cell0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .flush  (cfg_we),
        .shift  (b_advance),
        .clear  (b_reg.col_first),
        .col_in (col1),
        .col    (col0)
    );

    // Results: the cell one column left, plus the last column at row end
    assign push_a = c_advance && c_reg.row_ge1 && !c_reg.col_first;
    assign push_b = c_advance && c_reg.row_ge1 && c_reg.col_last;

    always_comb
    begin
        word_a.next_alive         = lgs_pkg::life_rule({col2, col1, col0});
        word_a.last_of_generation = 1'b0;
        word_b.next_alive         = lgs_pkg::life_rule({3'b000, col2, col1});
        word_b.last_of_generation = c_reg.row_last;
    end

    lgs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .word_a    (word_a),
        .push_b    (push_b),
        .word_b    (word_b),
        .room      (fifo_room),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_word  (result_word)
    );

endmodule

// ===== rtl/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the Life generation stream, bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cell_ready,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  lgs_pkg::out_word_t        result_word
);

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    // Valid drops only after a taken word
    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result valid dropped without handshake");

    // Input backpressure only with results waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ready |-> result_valid)
        else $error("input stalled while no result waits");

    // Reset held since the previous sample leaves nothing to deliver and the input open
    a_reset_idle: assert property (@(posedge clk)
        !rst_n && $past(!rst_n) |-> !result_valid && cell_ready)
        else $error("block not idle in reset");

endmodule

bind life_generation_stream lgs_checker u_lgs_checker (.*);
